// ===== hw/rtl/lkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared types and constants for the linear key/value table: request and
// response words, operation and status codes, field widths.
// ----------------------------------------------------------------------------
package lkvt_pkg;

	// Field widths of the request and response words, and the default table size
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 5;
	localparam int DEF_ENTRIES = 16;

	// Operation codes; code three is unused and changes nothing
	typedef enum logic [1:0] {
		OP_DEFINE = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Request word
	typedef struct packed {
		op_t                   operation;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} lkvt_req_t;

	// Response word
	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		status_t               status;
		logic [COUNT_BITS-1:0] entry_count;
	} lkvt_rsp_t;

endpackage

// ===== hw/rtl/linear_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_key_value_table_unit
// Sequence: a request word is accepted in IDLE; SCAN reads every entry in
//   turn, DRAIN takes the last registered read, and DONE writes back once
//   the output register can take the response. A new request word is taken
//   only in IDLE, after the previous one has been written back.
// Reset: a clearing pass marks every slot free; req_stall stays high until
//   it ends.
// Bounded key/value table with unique keys. Keys with a valid bit live in
// one synchronous memory, values in another; every operation scans all
// slots, then writes back at most one slot.
// ----------------------------------------------------------------------------
module linear_key_value_table_unit
	import lkvt_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  lkvt_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output lkvt_rsp_t rsp
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       addr_q;
	logic [CW-1:0]       count_q;
	lkvt_req_t           req_q;
	logic                hit_q;
	logic [AW-1:0]       hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                free_q;
	logic [AW-1:0]       free_idx_q;
	logic                rsp_valid_q;
	lkvt_rsp_t           rsp_q;

	// Read pipeline
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic [KEY_BITS:0]     key_rd_s1;
	logic [VALUE_BITS-1:0] val_rd_s1;

	// Memories: key memory carries the valid bit at the top
	logic [KEY_BITS:0]     key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];

	logic                  key_we;
	logic [AW-1:0]         key_waddr;
	logic [KEY_BITS:0]     key_wdata;
	logic                  val_we;
	logic [AW-1:0]         val_waddr;
	logic                  done_fire;
	logic                  rd_match;
	logic                  rd_free;
	logic [CW-1:0]         count_nxt;
	lkvt_rsp_t             rsp_nxt;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Result can leave when the output register is empty or being drained
	assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Compare of the word read back
	assign rd_match = rd_vld_s1 && key_rd_s1[KEY_BITS] && (key_rd_s1[KEY_BITS-1:0] == req_q.key);
	assign rd_free  = rd_vld_s1 && !key_rd_s1[KEY_BITS];

	// Write-back decision and response word
	always_comb begin
		logic [CW+COUNT_BITS-1:0] cnt_ext;
		key_we    = 1'b0;
		key_waddr = addr_q;
		key_wdata = '0;
		val_we    = 1'b0;
		val_waddr = hit_idx_q;
		count_nxt = count_q;
		rsp_nxt   = '0;
		rsp_nxt.found = hit_q;
		rsp_nxt.status = ST_OK;
		if (state_q == S_CLEAR) begin
			key_we = 1'b1;
		end
		case (req_q.operation)
			OP_DEFINE: begin
				if (hit_q) begin
					val_we = done_fire;
				end else if (free_q) begin
					key_we    = done_fire;
					key_waddr = free_idx_q;
					key_wdata = {1'b1, req_q.key};
					val_we    = done_fire;
					val_waddr = free_idx_q;
					count_nxt = count_q + CW'(1);
				end else begin
					rsp_nxt.status = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				if (hit_q) begin
					rsp_nxt.read_value = hit_val_q;
				end else begin
					rsp_nxt.status = ST_NOT_FOUND;
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					key_we    = done_fire;
					key_waddr = hit_idx_q;
					key_wdata = {1'b0, req_q.key};
					count_nxt = count_q - CW'(1);
				end else begin
					rsp_nxt.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		cnt_ext = {{COUNT_BITS{1'b0}}, count_nxt};
		rsp_nxt.entry_count = cnt_ext[COUNT_BITS-1:0];
	end

	// Memory ports: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rd_s1 <= key_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= req_q.value;
		end
		val_rd_s1 <= val_mem[addr_q];
	end

	// Sequencer: clearing pass, scan, write-back and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			count_q     <= '0;
			req_q       <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_val_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			rd_idx_s1 <= addr_q;
			// Output register: load on write-back, empty when taken
			if (done_fire) begin
				rsp_q       <= rsp_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			// Track lowest matching and lowest free slot
			if (rd_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				hit_val_q <= val_rd_s1;
			end
			if (rd_free && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Count never goes past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above table size");

	// No write-back while the scan reads the memories
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DRAIN) |-> (!key_we && !val_we))
		else $error("memory write during scan");

	// A new response only comes out of the write-back step
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response without write-back");

	// A full status is only reported for a full table
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ST_FULL) |-> (count_q == CW'(ENTRIES)))
		else $error("full status with free slots");
`endif

endmodule
